@@ rtl/lis_pkg.sv @@
// Shared constants and types for the longest increasing subsequence core.
// Used by every module of the block and by its checker.
`timescale 1ns / 1ps
package lis_pkg;
   localparam int MAX_LEN    = 1024;
   localparam int LEN_W      = $clog2(MAX_LEN + 1);
   localparam int VALUE_W    = 32;
   localparam int RUN_W      = 11;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [LEN_W-1:0]          len_type;

   typedef struct packed {
      logic grow;
      logic drop;
   } row_status_type;
endpackage

@@ rtl/lis_cell.sv @@
// One tail slot of the patience table: holds a tail, compares it with the
// broadcast word and hands its less flag to the right neighbor. Uses lis_pkg.
`timescale 1ns / 1ps
module lis_cell
   import lis_pkg::*;
(
   input  logic      clock,
   input  logic      step,
   input  value_type key,
   input  logic      occupied,
   input  logic      left_less,
   output logic      less,
   output logic      fill_free
);
   value_type tail_ff;
   logic      hit;

   assign less      = occupied && (tail_ff < key);
   assign hit       = !less && left_less;
   assign fill_free = hit && !occupied;

   always_ff @(posedge clock) begin
      if (step && hit) begin
         tail_ff <= key;
      end
   end
endmodule

@@ rtl/lis_row.sv @@
// Row of MAX_LEN tail cells; the occupied prefix follows the run length.
// Depends on lis_pkg and lis_cell.
`timescale 1ns / 1ps
module lis_row
   import lis_pkg::*;
(
   input  logic           clock,
   input  logic           step,
   input  value_type      key,
   input  len_type        len,
   output row_status_type status
);
   logic [MAX_LEN-1:0] less;
   logic [MAX_LEN-1:0] fill_free;
   logic [MAX_LEN-1:0] occupied;

   for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      logic left_less;

      assign occupied[k] = (LEN_W'(k) < len);

      if (k == 0) begin : g_first
         assign left_less = 1'b1;
      end else begin : g_rest
         assign left_less = less[k-1];
      end

      lis_cell u_cell (
         .clock     (clock),
         .step      (step),
         .key       (key),
         .occupied  (occupied[k]),
         .left_less (left_less),
         .less      (less[k]),
         .fill_free (fill_free[k])
      );
   end

   assign status.grow = |fill_free;
   assign status.drop = less[MAX_LEN-1];
endmodule

@@ rtl/longest_increasing_subseq_stream_core.sv @@
// The input word is registered in key_ff and its result word in rsp_data_ff.
// Throughput: one word per cycle while rsp_tready does not stall the result word; the
// compare across the whole cell row is combinational and the tail write lands on the same advance.
// Reset clears the run length, the overflow flag and both valid stages;
// tail cells are not cleared and are read only below the run length.
`timescale 1ns / 1ps
module longest_increasing_subseq_stream_core
   import lis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] value
   input  logic                  req_tlast,   // last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [10:0] run_length, [11] overflow, [15:12] zero
   output logic                  rsp_tlast    // is_final
);
   logic                  in_valid_ff;
   value_type             key_ff;
   logic                  last_ff;
   len_type               len_ff;
   len_type               len_in;
   logic                  ovf_ff;
   logic                  ovf_in;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic                  rsp_last_ff;
   logic                  advance;
   row_status_type        status;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   lis_row u_row (
      .clock  (clock),
      .step   (advance),
      .key    (key_ff),
      .len    (len_ff),
      .status (status)
   );

   assign len_in      = len_ff + LEN_W'(status.grow);
   assign ovf_in      = ovf_ff || status.drop;
   assign rsp_data_in = {{(RSP_DATA_W - RUN_W - 1){1'b0}}, ovf_in, RUN_W'(len_in)};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            len_ff       <= last_ff ? '0 : len_in;
            ovf_ff       <= last_ff ? 1'b0 : ovf_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         key_ff  <= value_type'(req_tdata[VALUE_W-1:0]);
         last_ff <= req_tlast;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule

@@ rtl/lis_checker.sv @@
// Port-level checks for the longest increasing subsequence core.
// Depends on lis_pkg; bound to longest_increasing_subseq_stream_core.
`timescale 1ns / 1ps
module lis_checker
   import lis_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RUN_W-1:0] != '0)
      else $error("run length zero");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RUN_W] |-> rsp_tdata[RUN_W-1:0] == RUN_W'(MAX_LEN))
      else $error("overflow without full table");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tlast))
      else $error("input word changed while stalled");
endmodule

bind longest_increasing_subseq_stream_core lis_checker u_lis_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for longest_increasing_subseq_stream_core.
// It predicts the running subsequence length word by word and checks every result word.
// Depends on lis_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_top;
   import lis_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PRINT_CAP    = 40;
   localparam int RANDOM_WORDS = 200;

   typedef struct {
      logic [RUN_W-1:0] run_length;
      logic             overflow;
      logic             is_final;
   } lis_result_type;

   typedef struct {
      value_type        value;
      logic             fin;
      logic             known;
      logic [RUN_W-1:0] run_length;
      logic             overflow;
   } stim_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   value_type      tail_keys [MAX_LEN];
   int             tail_count;
   logic           overflow_sticky;
   lis_result_type pending_lengths [$];

   int   error_count     = 0;
   int   words_sent      = 0;
   int   words_checked   = 0;
   int   sequences_sent  = 0;
   int   overflow_words  = 0;
   int   longest_run     = 0;
   int   cycle_count     = 0;
   logic req_calm        = 1'b0;
   logic rsp_calm        = 1'b0;
   int   rsp_stall_left  = 0;

   longest_increasing_subseq_stream_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Patience table update: append above the top, else replace the first tail not less.
   function automatic lis_result_type predict_lis_step(value_type v, logic fin);
      lis_result_type res;
      int lo;
      int hi;
      int mid;
      if (tail_count == 0) begin
         tail_keys[0] = v;
         tail_count   = 1;
      end else if (v > tail_keys[tail_count-1]) begin
         if (tail_count < MAX_LEN) begin
            tail_keys[tail_count] = v;
            tail_count++;
         end else begin
            overflow_sticky = 1'b1;
         end
      end else begin
         lo = 0;
         hi = tail_count;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tail_keys[mid] < v) lo = mid + 1;
            else hi = mid;
         end
         tail_keys[lo] = v;
      end
      res.run_length = tail_count[RUN_W-1:0];
      res.overflow   = overflow_sticky;
      res.is_final   = fin;
      if (fin) begin
         tail_count      = 0;
         overflow_sticky = 1'b0;
      end
      return res;
   endfunction

   // Mostly short gaps, a few long ones, none while calm.
   function automatic int pick_gap(logic calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      if (error_count < PRINT_CAP)
         $display("mismatch in %s at result word %0d: got %0d, expected %0d",
                  field, words_checked, got, want);
      error_count++;
   endtask

   task automatic send_word(value_type v, logic fin, logic known = 1'b0,
                            logic [RUN_W-1:0] len = '0, logic ovf = 1'b0);
      lis_result_type res;
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      res = predict_lis_step(v, fin);
      if (known) begin
         res.run_length = len;
         res.overflow   = ovf;
      end
      pending_lengths.push_back(res);
      words_sent++;
      if (fin) sequences_sent++;
   endtask

   // Result side: random stalls, with calm stretches.
   always @(posedge clock) begin
      lis_result_type want;
      if ($urandom_range(0, 299) == 0) rsp_calm <= ~rsp_calm;
      if (rsp_stall_left > 0) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else begin
         rsp_tready     <= 1'b1;
         rsp_stall_left <= pick_gap(rsp_calm);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lengths.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 0);
         end else begin
            want = pending_lengths.pop_front();
            if (rsp_tdata[RUN_W-1:0] !== want.run_length)
               report_mismatch("run_length", rsp_tdata[RUN_W-1:0], want.run_length);
            if (rsp_tdata[RUN_W] !== want.overflow)
               report_mismatch("overflow", rsp_tdata[RUN_W], want.overflow);
            if (rsp_tdata[RSP_DATA_W-1:RUN_W+1] !== '0)
               report_mismatch("pad bits", rsp_tdata[RSP_DATA_W-1:RUN_W+1], 0);
            if (rsp_tlast !== want.is_final)
               report_mismatch("is_final", rsp_tlast, want.is_final);
            if (want.overflow) overflow_words++;
            if (int'(want.run_length) > longest_run) longest_run = int'(want.run_length);
         end
         words_checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_lengths.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      stim_row_type directed [] = '{
         '{32'h8000_0000, 1'b0, 1'b1, 11'd1, 1'b0},
         '{32'h8000_0000, 1'b0, 1'b1, 11'd1, 1'b0},
         '{32'h7FFF_FFFF, 1'b0, 1'b1, 11'd2, 1'b0},
         '{32'h7FFF_FFFF, 1'b0, 1'b1, 11'd2, 1'b0},
         '{32'h0000_0000, 1'b0, 1'b1, 11'd2, 1'b0},
         '{32'hFFFF_FFFF, 1'b0, 1'b1, 11'd2, 1'b0},
         '{32'h0000_0001, 1'b1, 1'b1, 11'd3, 1'b0},
         '{32'h7FFF_FFFF, 1'b1, 1'b1, 11'd1, 1'b0},
         '{32'h8000_0000, 1'b1, 1'b1, 11'd1, 1'b0},
         '{32'd5,         1'b0, 1'b0, 11'd0, 1'b0},
         '{32'd3,         1'b0, 1'b0, 11'd0, 1'b0},
         '{32'd4,         1'b0, 1'b0, 11'd0, 1'b0},
         '{32'd1,         1'b0, 1'b0, 11'd0, 1'b0},
         '{32'd2,         1'b0, 1'b0, 11'd0, 1'b0},
         '{32'd6,         1'b0, 1'b0, 11'd0, 1'b0},
         '{32'd0,         1'b0, 1'b0, 11'd0, 1'b0},
         '{32'd7,         1'b1, 1'b0, 11'd0, 1'b0},
         '{32'hAAAA_AAAA, 1'b0, 1'b0, 11'd0, 1'b0},
         '{32'h5555_5555, 1'b1, 1'b0, 11'd0, 1'b0}
      };
      int        random_words;
      int        seq_len;
      int        kind;
      value_type v;

      tail_count      = 0;
      overflow_sticky = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_word(directed[i].value, directed[i].fin, directed[i].known,
                   directed[i].run_length, directed[i].overflow);

      // Fill the table past its depth, then replace and overflow again on a full table.
      for (int i = 0; i <= MAX_LEN; i++) send_word(i * 3 - 1500, 1'b0);
      send_word(-1600, 1'b0);
      send_word(32'h7FFF_FFFF, 1'b1, 1'b1, 11'(MAX_LEN), 1'b1);

      random_words = 0;
      while (random_words < RANDOM_WORDS) begin
         req_calm = ($urandom_range(0, 3) == 0);
         kind     = $urandom_range(0, 9);
         seq_len  = $urandom_range(1, 30);
         if (kind == 8) seq_len = 1;
         if (kind >= 6 && kind < 8) seq_len = $urandom_range(1, 60);
         v = $urandom;
         for (int i = 0; i < seq_len; i++) begin
            case (kind)
               4, 5: begin
                  v = $signed($urandom_range(0, 8)) - 4;
               end
               6, 7: begin
                  v = v + $signed($urandom_range(0, 2000)) - 300;
               end
               9: begin
                  v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
               end
               default: begin
                  v = $urandom;
               end
            endcase
            send_word(v, i == seq_len - 1);
            random_words++;
         end
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      while (pending_lengths.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d words in %0d sequences, longest run %0d, %0d overflow results",
               words_sent, sequences_sent, longest_run, overflow_words);
      $display("%0d result words checked, %0d mismatches", words_checked, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
